// File: src/lkvc_pkg.sv
// lkvc_pkg: types and constants shared by the LRU key-value cache.
// Holds the controller/datapath command and status structs and the field widths.
// No dependencies.
`default_nettype none

package lkvc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // what the update cycle does to the store
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_HIT_GET = 3'd1,
    ACT_HIT_PUT = 3'd2,
    ACT_INSERT  = 3'd3,
    ACT_EVICT   = 3'd4
  } act_e;

  typedef struct packed {
    logic load;  // capture the input item
    logic cmp;   // register the key and victim match vectors
    logic upd;   // apply act to ranks and stores, start RAM reads
    logic rsp;   // load the output register
    act_e act;
  } lkvc_cmd_t;

  typedef struct packed {
    logic hit;       // key present
    logic is_put;
    logic room;      // occupancy below the effective limit
    logic lim_zero;  // effective limit is zero
  } lkvc_stat_t;

endpackage

`default_nettype wire

// File: src/lru_key_value_cache_top.sv
// lru_key_value_cache_top: fully associative key-value cache with LRU replacement.
// Joins lkvc_ctrl and lkvc_datapath. Uses lkvc_pkg.
//
//  channel  | direction | tdata (low bit up)          | tuser (low bit up)
//  s_axis   | in        | key[31:0], value[63:32]     | kind (0 get, 1 put)
//  m_axis   | out       | read_value[31:0],           | found[0], evicted[1]
//           |           | evicted_key[63:32]          |
//  cfg      | in        | capacity_limit on cfg_wdata_i, written when cfg_we_i is high
//
// An item goes through three steps: compare against every key cell, update ranks and
// stores, then register the result once the value/key RAM reads return.
// The next item is taken in the cycle its predecessor's result is loaded; none is
// taken while an item is in the compare or update step.
// A stalled m_axis holds one finished result; one more item is taken and then waits.
// Reset empties the cache and sets the capacity limit to 16; no clearing pass.
`default_nettype none

module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [63:0]      s_axis_tdata,   // key[31:0], value[63:32]
  input  wire logic             s_axis_tuser,   // kind
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [63:0]      m_axis_tdata,   // read_value[31:0], evicted_key[63:32]
  output logic      [1:0]       m_axis_tuser    // found[0], evicted[1]
);

  lkvc_cmd_t  cmd;
  lkvc_stat_t stat;
  logic             found, evicted;
  logic [VAL_W-1:0] read_value;
  logic [KEY_W-1:0] evicted_key;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_kind_i         (s_axis_tuser),
    .in_key_i          (s_axis_tdata[KEY_W-1:0]),
    .in_value_i        (s_axis_tdata[KEY_W +: VAL_W]),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_found_o       (found),
    .out_read_value_o  (read_value),
    .out_evicted_o     (evicted),
    .out_evicted_key_o (evicted_key)
  );

  assign m_axis_tdata = {evicted_key, read_value};
  assign m_axis_tuser = {evicted, found};

endmodule

`default_nettype wire

// File: src/lkvc_ram.sv
// lkvc_ram: generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/lkvc_ctrl.sv
// lkvc_ctrl: sequencing state machine of the LRU cache.
// Runs the compare/update/respond steps and the stream handshakes. Uses lkvc_pkg.
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire lkvc_stat_t stat_i,
  output lkvc_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_RSP  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_ready;
  act_e   act;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (stat_i.hit) begin
      act = stat_i.is_put ? ACT_HIT_PUT : ACT_HIT_GET;
    end else if (!stat_i.is_put || stat_i.lim_zero) begin
      act = ACT_NONE;
    end else if (stat_i.room) begin
      act = ACT_INSERT;
    end else begin
      act = ACT_EVICT;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    cmd_o    = '{load: 1'b0, cmp: 1'b0, upd: 1'b0, rsp: 1'b0, act: act};
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_RSP;
      end
      S_RSP: begin
        if (out_free) begin
          cmd_o.rsp = 1'b1;
          in_ready  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (in_ready && in_valid_i) begin
      cmd_o.load = 1'b1;
      state_d    = S_CMP;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.rsp) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.rsp)
    else $error("result overwritten while waiting");

  // an accepted item always goes through compare next
  a_load_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.cmp)
    else $error("accepted item skipped compare");

  // the update step always follows compare
  a_cmp_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cmp |=> cmd_o.upd)
    else $error("compare not followed by update");

endmodule

`default_nettype wire

// File: src/lkvc_datapath.sv
// lkvc_datapath: key cells, recency ranks, occupancy, value and key RAMs, result register.
// Driven by lkvc_ctrl commands. Uses lkvc_pkg and lkvc_ram.
`default_nettype none

module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  input  wire logic             in_kind_i,
  input  wire logic [KEY_W-1:0] in_key_i,
  input  wire logic [VAL_W-1:0] in_value_i,
  input  wire lkvc_cmd_t        cmd_i,
  output lkvc_stat_t            stat_o,
  output logic                  out_found_o,
  output logic [VAL_W-1:0]      out_read_value_o,
  output logic                  out_evicted_o,
  output logic [KEY_W-1:0]      out_evicted_key_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [CAP_W-1:0] cap_q;
  logic             op_kind_q;
  logic [KEY_W-1:0] op_key_q;
  logic [VAL_W-1:0] op_val_q;
  logic [KEY_W-1:0] key_q  [ENTRIES];
  logic [IDX_W-1:0] rank_q [ENTRIES];
  logic [IDX_W-1:0] rank_d [ENTRIES];
  logic [OCC_W-1:0] occ_q, occ_d, occ_m1;
  logic [ENTRIES-1:0] valid, hit_vec_q, hit_vec_d, vic_vec_q, vic_vec_d;

  logic [LIM_W-1:0] cap_ext, lim;
  logic [IDX_W-1:0] hit_idx, hit_rank, vic_idx, sel_idx, old_rank;
  logic             touch, wr_key, wr_val;

  logic res_found_q, res_get_q, res_evict_q, res_hitget_q;
  logic [VAL_W-1:0] val_rdata;
  logic [KEY_W-1:0] key_rdata;
  logic             out_found_q, out_evicted_q;
  logic [VAL_W-1:0] out_read_value_q;
  logic [KEY_W-1:0] out_evicted_key_q;

  // entries fill from slot 0 upward and are never freed
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i] = OCC_W'(i) < occ_q;
    end
  end

  assign occ_m1  = occ_q - OCC_W'(1);
  assign cap_ext = LIM_W'(cap_q);
  assign lim     = (cap_ext > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : cap_ext;

  // compare: one comparator per entry; the oldest valid entry holds rank occ-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_d[i] = valid[i] && (key_q[i] == op_key_q);
      vic_vec_d[i] = valid[i] && (rank_q[i] == occ_m1[IDX_W-1:0]);
    end
  end

  // one-hot to index, AND-OR of the hit rank
  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    vic_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_q[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (vic_vec_q[i]) begin
        vic_idx = vic_idx | IDX_W'(i);
      end
    end
  end

  assign stat_o.hit      = |hit_vec_q;
  assign stat_o.is_put   = (op_kind_q == KIND_PUT);
  assign stat_o.room     = LIM_W'(occ_q) < lim;
  assign stat_o.lim_zero = (lim == '0);

  always_comb begin
    sel_idx  = hit_idx;
    old_rank = hit_rank;
    touch    = 1'b0;
    wr_key   = 1'b0;
    wr_val   = 1'b0;
    occ_d    = occ_q;
    case (cmd_i.act)
      ACT_HIT_GET: begin
        touch = cmd_i.upd;
      end
      ACT_HIT_PUT: begin
        touch  = cmd_i.upd;
        wr_val = cmd_i.upd;
      end
      ACT_INSERT: begin
        sel_idx  = occ_q[IDX_W-1:0];
        old_rank = occ_q[IDX_W-1:0];
        touch    = cmd_i.upd;
        wr_key   = cmd_i.upd;
        wr_val   = cmd_i.upd;
        if (cmd_i.upd) begin
          occ_d = occ_q + OCC_W'(1);
        end
      end
      ACT_EVICT: begin
        sel_idx  = vic_idx;
        old_rank = occ_m1[IDX_W-1:0];
        touch    = cmd_i.upd;
        wr_key   = cmd_i.upd;
        wr_val   = cmd_i.upd;
      end
      default: ;
    endcase
  end

  // touched entry becomes rank 0; younger valid entries age by one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (touch) begin
        if (sel_idx == IDX_W'(i)) begin
          rank_d[i] = '0;
        end else if (valid[i] && (rank_q[i] < old_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      occ_q     <= '0;
      hit_vec_q <= '0;
      vic_vec_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.cmp) begin
        hit_vec_q <= hit_vec_d;
        vic_vec_q <= vic_vec_d;
      end
      occ_q <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_kind_q <= in_kind_i;
      op_key_q  <= in_key_i;
      op_val_q  <= in_value_i;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_key && (sel_idx == IDX_W'(i))) begin
        key_q[i] <= op_key_q;
      end
    end
    if (cmd_i.upd) begin
      res_found_q  <= |hit_vec_q;
      res_get_q    <= (op_kind_q == KIND_GET);
      res_evict_q  <= (cmd_i.act == ACT_EVICT);
      res_hitget_q <= (cmd_i.act == ACT_HIT_GET);
    end
    if (cmd_i.rsp) begin
      out_found_q       <= res_found_q;
      out_evicted_q     <= res_evict_q;
      out_read_value_q  <= res_hitget_q ? val_rdata : (res_get_q ? '1 : '0);
      out_evicted_key_q <= res_evict_q ? key_rdata : '0;
    end
  end

  lkvc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (wr_val),
    .waddr_i (sel_idx),
    .wdata_i (op_val_q),
    .re_i    (cmd_i.upd),
    .raddr_i (hit_idx),
    .rdata_o (val_rdata)
  );

  // mirror of the key cells, read at the victim (old contents on collision)
  lkvc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_key),
    .waddr_i (sel_idx),
    .wdata_i (op_key_q),
    .re_i    (cmd_i.upd),
    .raddr_i (vic_idx),
    .rdata_o (key_rdata)
  );

  assign out_found_o       = out_found_q;
  assign out_read_value_o  = out_read_value_q;
  assign out_evicted_o     = out_evicted_q;
  assign out_evicted_key_o = out_evicted_key_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIM_W'(occ_q) <= LIM_W'(ENTRIES))
    else $error("occupancy above entry count");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec_q))
    else $error("key present in more than one entry");

  a_victim_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd && cmd_i.act == ACT_EVICT) |-> $onehot(vic_vec_q))
    else $error("eviction without a single oldest entry");

  a_occ_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd && cmd_i.act == ACT_INSERT) |=> occ_q == $past(occ_q) + OCC_W'(1))
    else $error("insert did not grow occupancy");

endmodule

`default_nettype wire

// File: bench/tb.sv
// tb: self-checking bench for lru_key_value_cache_top.
// Drives get/put transfers, predicts each result with a behavioural LRU model
// and checks every output transfer field by field. Depends on lkvc_pkg.

module tb;
  import lkvc_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned PRINT_CAP       = 40;
  localparam int unsigned POOL_SIZE       = 24;
  localparam int unsigned SEGMENTS        = 15;
  localparam int unsigned SEGMENT_OPS     = 107;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lookup_rsp_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata  = '0;   // key[31:0], value[63:32]
  logic             s_axis_tuser  = KIND_GET;  // kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;         // read_value[31:0], evicted_key[63:32]
  logic [1:0]       m_axis_tuser;         // found[0], evicted[1]

  // behavioural copy of the cache
  logic [KEY_W-1:0] cache_key   [ENTRIES_DEF];
  logic [VAL_W-1:0] cache_val   [ENTRIES_DEF];
  bit               cache_valid [ENTRIES_DEF];
  int unsigned      cache_rank  [ENTRIES_DEF];
  int unsigned      cache_count = 0;
  logic [CAP_W-1:0] cache_limit = CAP_RESET;

  lookup_rsp_t      expected_rsp [$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned src_gap_pct    = 7;
  int unsigned sink_stall_pct = 54;
  int unsigned mismatches     = 0;
  int unsigned ops_sent       = 0;
  int unsigned hits_seen      = 0;
  int unsigned evictions_seen = 0;
  int unsigned limit_writes   = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles   = 0;

  lru_key_value_cache_top #(
    .ENTRIES(ENTRIES_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // entry s becomes most recent; valid entries younger than old_rank age by one
  function automatic void promote_entry(int unsigned s, int unsigned old_rank);
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (cache_valid[i] && i != s && cache_rank[i] < old_rank) cache_rank[i]++;
    end
    cache_rank[s] = 0;
  endfunction

  function automatic lookup_rsp_t lru_lookup(logic kind, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] val);
    int unsigned eff;
    int unsigned hit;
    int unsigned slot;
    int unsigned victim;
    int unsigned oldest;
    lookup_rsp_t r;
    eff    = (cache_limit > ENTRIES_DEF) ? ENTRIES_DEF : cache_limit;
    hit    = ENTRIES_DEF;
    slot   = ENTRIES_DEF;
    victim = ENTRIES_DEF;
    oldest = 0;
    r      = '0;
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (hit == ENTRIES_DEF && cache_valid[i] && cache_key[i] == key) hit = i;
    end
    if (hit < ENTRIES_DEF) begin
      r.found = 1'b1;
      promote_entry(hit, cache_rank[hit]);
      if (kind == KIND_GET) r.read_value = cache_val[hit];
      else cache_val[hit] = val;
    end else if (kind == KIND_GET) begin
      r.read_value = '1;
    end else if (eff != 0) begin
      if (cache_count < eff) begin
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (slot == ENTRIES_DEF && !cache_valid[i]) slot = i;
        end
        cache_key[slot]   = key;
        cache_val[slot]   = val;
        cache_valid[slot] = 1'b1;
        promote_entry(slot, cache_count);
        cache_count++;
      end else begin
        // limit may sit below occupancy: replace the oldest, occupancy unchanged
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (cache_valid[i] && (victim == ENTRIES_DEF || cache_rank[i] > oldest)) begin
            victim = i;
            oldest = cache_rank[i];
          end
        end
        r.evicted       = 1'b1;
        r.evicted_key   = cache_key[victim];
        cache_key[victim] = key;
        cache_val[victim] = val;
        promote_entry(victim, oldest);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : check_rsp
    lookup_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding", '0, m_axis_tdata[31:0]);
      end else begin
        want = expected_rsp.pop_front();
        results_checked++;
        if (m_axis_tuser[0] !== want.found)
          report_mismatch("found", want.found, m_axis_tuser[0]);
        if (m_axis_tdata[31:0] !== want.read_value)
          report_mismatch("read_value", want.read_value, m_axis_tdata[31:0]);
        if (m_axis_tuser[1] !== want.evicted)
          report_mismatch("evicted", want.evicted, m_axis_tuser[1]);
        if (m_axis_tdata[63:32] !== want.evicted_key)
          report_mismatch("evicted_key", want.evicted_key, m_axis_tdata[63:32]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_rsp.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_op(input logic kind, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
    lookup_rsp_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, key};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    r = lru_lookup(kind, key, val);
    expected_rsp.push_back(r);
    ops_sent++;
    hits_seen      += r.found;
    evictions_seen += r.evicted;
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] lim);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cache_limit = lim;
    limit_writes++;
  endtask

  task automatic test_extreme_keys();
    send_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);  // miss on an empty cache
    send_op(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_op(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_op(KIND_GET, 32'h8000_0000, 32'h0000_0000);
    send_op(KIND_GET, 32'hffff_ffff, 32'h1234_5678);  // hit returning all ones
    send_op(KIND_PUT, 32'h7fff_ffff, 32'h0000_0000);  // update in place
    send_op(KIND_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(KIND_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  // three entries held, limit 1: each new key replaces the oldest
  task automatic test_shrunk_capacity();
    set_capacity(5'd1);
    send_op(KIND_PUT, 32'd5, 32'd55);
    send_op(KIND_PUT, 32'd6, 32'd66);
    send_op(KIND_GET, 32'd5, 32'd0);
    send_op(KIND_GET, 32'h7fff_ffff, 32'd0);
  endtask

  task automatic test_zero_capacity();
    set_capacity(5'd0);
    send_op(KIND_PUT, 32'd7, 32'd77);
    send_op(KIND_GET, 32'd7, 32'd0);
    send_op(KIND_PUT, 32'd6, 32'd99);
    send_op(KIND_GET, 32'd6, 32'd0);
  endtask

  // limit above the entry count behaves as the entry count
  task automatic test_oversized_limit();
    set_capacity(5'd31);
    send_op(KIND_PUT, 32'd8, 32'd88);
    send_op(KIND_PUT, 32'd9, 32'd99);
    send_op(KIND_GET, 32'd8, 32'd0);
    send_op(KIND_PUT, 32'hdead_beef, 32'h0bad_f00d);
  endtask

  task automatic test_random_segment(input logic [CAP_W-1:0] lim, input int unsigned n_ops);
    int unsigned eff;
    int unsigned span;
    logic        kind;
    logic [KEY_W-1:0] key;
    set_capacity(lim);
    repeat (6) key_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
    eff  = (lim > ENTRIES_DEF) ? ENTRIES_DEF : lim;
    span = eff + 4;
    if (span > POOL_SIZE) span = POOL_SIZE;
    if (span < 3) span = 3;
    repeat (n_ops) begin
      kind = $urandom_range(1) ? KIND_PUT : KIND_GET;
      if ($urandom_range(9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(span-1)];
      send_op(kind, key, $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] seg_limit [SEGMENTS];
    seg_limit = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd4,
                  5'd16, 5'd2, 5'd17, 5'd8, 5'd0,
                  5'd3, 5'd12, 5'd1, 5'd31, 5'd16};
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extreme_keys();
    test_shrunk_capacity();
    test_zero_capacity();
    test_oversized_limit();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 5) begin
        src_gap_pct    = 54;
        sink_stall_pct = 7;
      end else if (seg == 10) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      test_random_segment(seg_limit[seg], SEGMENT_OPS);
    end
    drain_results();

    $display("covered %0d get/put operations: %0d hits, %0d evictions, %0d limit writes",
             ops_sent, hits_seen, evictions_seen, limit_writes);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lkvc_pkg.sv
src/lkvc_ram.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache_top.sv
bench/tb.sv
